// File: rtl/lfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lfsa_pkg
// Types and constants for the lowest free slot allocator: sizes, command and
// status codes, register indexes, the requester table entry and the states.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  localparam int MAX_SLOTS      = 64;
  localparam int SLOT_BITS      = 6;
  localparam int MAX_REQUESTERS = 1024;
  localparam int REQ_BITS       = 10;
  localparam int TIME_BITS      = 31;
  localparam int BUSY_BITS      = 48;
  localparam int COUNT_BITS     = 7;   // total_slots and best_position
  localparam int ADDR_BITS      = 3;

  localparam logic [BUSY_BITS-1:0] BUSY_MAX = {BUSY_BITS{1'b1}};

  // Input commands.
  localparam logic [1:0] CMD_ARRIVE = 2'd0;
  localparam logic [1:0] CMD_DEPART = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_GRANTED  = 2'd0;
  localparam logic [1:0] STS_REJECTED = 2'd1;
  localparam logic [1:0] STS_RELEASED = 2'd2;
  localparam logic [1:0] STS_REPORT   = 2'd3;

  // Register index, taken from paddr[2].
  localparam logic REG_TOTAL_SLOTS  = 1'b0;
  localparam logic REG_WINDOW_START = 1'b1;

  typedef struct packed {
    logic                 granted;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] arrival;
  } req_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ARRIVE,
    ST_DEP_READ,
    ST_DEP_ADD,
    ST_REP_START,
    ST_SCAN,
    ST_RESP
  } state_t;

endpackage : lfsa_pkg
`default_nettype wire

// File: rtl/lowest_free_slot_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator_unit
// Grants the lowest free slot to arriving requesters, frees it on departure
// while adding the held time to the slot's saturating busy total, and reports
// the least busy slot of a window by scanning the busy total memory.
// ----------------------------------------------------------------------------
// Arrive picks the lowest free slot; depart reads the requester table and,
// when the requester holds a slot, does a read-modify-write of the busy
// total; report reads one busy total per slot of the window. One item is in
// work at a time; the next input can be taken in the cycle after the result
// is loaded into the output register.
// After reset a clearing pass walks all 1024 requester table entries while
// no input is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input stream.
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [47:0]                    s_tdata,  // requester_id[9:0], event_time[40:10]
  input  wire logic [1:0]                     s_tuser,  // command[1:0]
  // Result stream.
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [63:0]                         m_tdata,  // slot[5:0], least_busy_time[53:6],
                                                        // best_position[60:54]
  output logic [1:0]                          m_tuser,  // status[1:0]
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lfsa_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import lfsa_pkg::*;

  // Configuration registers.
  logic [COUNT_BITS-1:0] total_slots;
  logic [SLOT_BITS-1:0]  window_start;

  state_t state, state_next;

  // Latched input item.
  logic [REQ_BITS-1:0]  who;
  logic [TIME_BITS-1:0] evt_time;

  logic [MAX_SLOTS-1:0] free_map;
  logic [MAX_SLOTS-1:0] busy_valid;
  logic [REQ_BITS-1:0]  clear_idx;

  // Requester table.
  req_entry_t          req_mem [MAX_REQUESTERS];
  req_entry_t          req_rdata;
  logic                req_re;
  logic [REQ_BITS-1:0] req_raddr;
  logic                req_we;
  logic [REQ_BITS-1:0] req_waddr;
  req_entry_t          req_wdata;

  // Busy total memory.
  logic [BUSY_BITS-1:0] busy_mem [MAX_SLOTS];
  logic [BUSY_BITS-1:0] busy_rdata;
  logic [SLOT_BITS-1:0] busy_raddr_q;
  logic                 busy_re;
  logic [SLOT_BITS-1:0] busy_raddr;
  logic                 busy_we;
  logic [BUSY_BITS-1:0] busy_wdata;
  logic [BUSY_BITS-1:0] busy_value;

  // Depart and scan working registers.
  logic [SLOT_BITS-1:0]  dep_slot;
  logic [TIME_BITS-1:0]  dep_arrival;
  logic [SLOT_BITS-1:0]  scan_idx;
  logic                  scan_first;
  logic [BUSY_BITS-1:0]  best_val;
  logic [COUNT_BITS-1:0] best_pos;

  // Pending result.
  logic [1:0]            res_status;
  logic [SLOT_BITS-1:0]  res_slot;
  logic [BUSY_BITS-1:0]  res_least;
  logic [COUNT_BITS-1:0] res_pos;

  // Output register.
  logic [1:0]            out_status;
  logic [SLOT_BITS-1:0]  out_slot;
  logic [BUSY_BITS-1:0]  out_least;
  logic [COUNT_BITS-1:0] out_pos;

  logic                  in_xfer;
  logic                  out_free;
  logic                  cfg_write;

  // Lowest free slot below total_slots.
  logic                  have_free;
  logic [SLOT_BITS-1:0]  free_slot;

  logic                  win_empty;
  logic                  scan_last;
  logic [COUNT_BITS-1:0] scan_pos;
  logic [TIME_BITS-1:0]  duration;
  logic [BUSY_BITS:0]    busy_sum;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign s_tready  = (state == ST_IDLE);
  assign in_xfer   = s_tvalid & s_tready;
  assign out_free  = ~m_tvalid | m_tready;

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_pos, out_least, out_slot};

  always_comb begin
    case (paddr[2])
      REG_TOTAL_SLOTS:  prdata = {{(32-COUNT_BITS){1'b0}}, total_slots};
      REG_WINDOW_START: prdata = {{(32-SLOT_BITS){1'b0}}, window_start};
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (free_map[i] && (COUNT_BITS'(i) < total_slots)) begin
        have_free = 1'b1;
        free_slot = SLOT_BITS'(i);
      end
    end
  end

  assign win_empty  = ({1'b0, window_start} >= total_slots);
  assign scan_last  = (scan_idx == SLOT_BITS'(MAX_SLOTS - 1)) ||
                      (({1'b0, scan_idx} + COUNT_BITS'(1)) >= total_slots);
  assign scan_pos   = {1'b0, scan_idx} - {1'b0, window_start} + COUNT_BITS'(1);
  assign busy_value = busy_valid[busy_raddr_q] ? busy_rdata : '0;
  assign duration   = (evt_time >= dep_arrival) ? (evt_time - dep_arrival) : '0;
  assign busy_sum   = {1'b0, busy_value} + {{(BUSY_BITS+1-TIME_BITS){1'b0}}, duration};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_idx == REQ_BITS'(MAX_REQUESTERS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_tuser)
            CMD_ARRIVE: state_next = ST_ARRIVE;
            CMD_DEPART: state_next = ST_DEP_READ;
            CMD_REPORT: state_next = ST_REP_START;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_ARRIVE:    state_next = ST_RESP;
      ST_DEP_READ:  state_next = req_rdata.granted ? ST_DEP_ADD : ST_RESP;
      ST_DEP_ADD:   state_next = ST_RESP;
      ST_REP_START: state_next = win_empty ? ST_RESP : ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // Memory controls.
  always_comb begin
    req_re     = 1'b0;
    req_raddr  = s_tdata[REQ_BITS-1:0];
    req_we     = 1'b0;
    req_waddr  = who;
    req_wdata  = '0;
    busy_re    = 1'b0;
    busy_raddr = window_start;
    busy_we    = 1'b0;
    busy_wdata = (busy_sum > {1'b0, BUSY_MAX}) ? BUSY_MAX : busy_sum[BUSY_BITS-1:0];
    case (state)
      ST_CLEAR: begin
        req_we    = 1'b1;
        req_waddr = clear_idx;
      end
      ST_IDLE: begin
        req_re = in_xfer;
      end
      ST_ARRIVE: begin
        if (have_free) begin
          req_we            = 1'b1;
          req_wdata.granted = 1'b1;
          req_wdata.slot    = free_slot;
          req_wdata.arrival = evt_time;
        end
      end
      ST_DEP_READ: begin
        if (req_rdata.granted) begin
          req_we     = 1'b1;
          req_wdata  = req_rdata;
          req_wdata.granted = 1'b0;
          busy_re    = 1'b1;
          busy_raddr = req_rdata.slot;
        end
      end
      ST_DEP_ADD: begin
        busy_we = 1'b1;
      end
      ST_REP_START: begin
        busy_re    = ~win_empty;
        busy_raddr = window_start;
      end
      ST_SCAN: begin
        busy_re    = ~scan_last;
        busy_raddr = scan_idx + SLOT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_we) req_mem[req_waddr] <= req_wdata;
    if (req_re) req_rdata <= req_mem[req_raddr];
  end

  always_ff @(posedge clk) begin
    if (busy_we) busy_mem[dep_slot] <= busy_wdata;
    if (busy_re) begin
      busy_rdata   <= busy_mem[busy_raddr];
      busy_raddr_q <= busy_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      total_slots  <= COUNT_BITS'(63);
      window_start <= SLOT_BITS'(31);
      free_map     <= '1;
      busy_valid   <= '0;
      clear_idx    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (paddr[2])
          REG_TOTAL_SLOTS:  total_slots  <= pwdata[COUNT_BITS-1:0];
          REG_WINDOW_START: window_start <= pwdata[SLOT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (state == ST_CLEAR) clear_idx <= clear_idx + REQ_BITS'(1);
      if ((state == ST_ARRIVE) && have_free) free_map[free_slot] <= 1'b0;
      if (state == ST_DEP_ADD) begin
        free_map[dep_slot]   <= 1'b1;
        busy_valid[dep_slot] <= 1'b1;
      end
      if ((state == ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      who      <= s_tdata[REQ_BITS-1:0];
      evt_time <= s_tdata[REQ_BITS+TIME_BITS-1:REQ_BITS];
    end
    case (state)
      ST_ARRIVE: begin
        res_status <= have_free ? STS_GRANTED : STS_REJECTED;
        res_slot   <= have_free ? free_slot : '0;
        res_least  <= '0;
        res_pos    <= '0;
      end
      ST_DEP_READ: begin
        dep_slot    <= req_rdata.slot;
        dep_arrival <= req_rdata.arrival;
        res_status  <= req_rdata.granted ? STS_RELEASED : STS_REJECTED;
        res_slot    <= req_rdata.granted ? req_rdata.slot : '0;
        res_least   <= '0;
        res_pos     <= '0;
      end
      ST_REP_START: begin
        scan_idx   <= window_start;
        scan_first <= 1'b1;
        res_status <= STS_REPORT;
        res_slot   <= '0;
        res_least  <= '0;
        res_pos    <= '0;
      end
      ST_SCAN: begin
        // The value read in the previous cycle belongs to scan_idx.
        if (scan_first || (busy_value < best_val)) begin
          best_val <= busy_value;
          best_pos <= scan_pos;
        end
        if (scan_last) begin
          res_least <= (scan_first || (busy_value < best_val)) ? busy_value : best_val;
          res_pos   <= (scan_first || (busy_value < best_val)) ? scan_pos : best_pos;
        end
        scan_first <= 1'b0;
        scan_idx   <= scan_idx + SLOT_BITS'(1);
      end
      default: begin
      end
    endcase
    if ((state == ST_RESP) && out_free) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_least  <= res_least;
      out_pos    <= res_pos;
    end
  end

endmodule : lowest_free_slot_allocator_unit
`default_nettype wire
